// ===== rtl/kdwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kdwm_pkg
// Shared widths, register indexes and types for the disjoint window max sum.
// ----------------------------------------------------------------------------
package kdwm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MAX_COUNT  = 16;

  localparam int VALUE_W = 30;
  localparam int SUM_W   = 36;
  localparam int TOTAL_W = 40;
  localparam int LEN_W   = 7;
  localparam int CNT_W   = 5;

  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int J_W        = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int ROW_ADDR_W = SLOT_W + J_W;
  localparam int ROW_DEPTH  = MAX_WINDOW * MAX_COUNT;
  localparam int FILL_MAX   = 2 * MAX_WINDOW;
  localparam int FILL_W     = $clog2(FILL_MAX + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 2'd1;

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [CNT_W-1:0] window_count;
  } cfg_t;

endpackage

// ===== rtl/kdwm_ram.sv =====
// ----------------------------------------------------------------------------
// kdwm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kdwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kdwm_cfg.sv =====
// ----------------------------------------------------------------------------
// kdwm_cfg
// Configuration registers with range clamping; flags a stream clear on write.
// ----------------------------------------------------------------------------
module kdwm_cfg import kdwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic                  clear
);

  logic [LEN_W-1:0] len_next;
  logic [CNT_W-1:0] count_next;
  logic             wr;

  assign wr    = cfg_valid & cfg_ready;
  assign clear = wr & ((cfg_index == REG_WINDOW_LEN) | (cfg_index == REG_WINDOW_COUNT));

  always_comb begin
    len_next   = cfg_data[LEN_W-1:0];
    count_next = cfg_data[CNT_W-1:0];
    if (len_next == '0) begin
      len_next = LEN_W'(1);
    end else if (len_next > LEN_W'(MAX_WINDOW)) begin
      len_next = LEN_W'(MAX_WINDOW);
    end
    if (count_next > CNT_W'(MAX_COUNT)) begin
      count_next = CNT_W'(MAX_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len   <= LEN_W'(1);
      cfg.window_count <= CNT_W'(1);
    end else if (wr) begin
      unique case (cfg_index)
        REG_WINDOW_LEN:   cfg.window_len   <= len_next;
        REG_WINDOW_COUNT: cfg.window_count <= count_next;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/kdwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kdwm_ctrl
// Item sequencer: updates the running window sum through the delay line
// memory, then walks the row entries of the current slot one per cycle.
// ----------------------------------------------------------------------------
module kdwm_ctrl import kdwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  clear,
  input  logic                  cfg_valid,
  output logic                  idle,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_W-1:0]    sample_value,
  input  logic                  last_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOTAL_W-1:0]    best_total,
  output logic                  dly_we,
  output logic [SLOT_W-1:0]     dly_addr,
  output logic [VALUE_W-1:0]    dly_wdata,
  input  logic [VALUE_W-1:0]    dly_rdata,
  output logic                  row_we,
  output logic [ROW_ADDR_W-1:0] row_waddr,
  output logic [TOTAL_W-1:0]    row_wdata,
  output logic [ROW_ADDR_W-1:0] keep_raddr,
  output logic [ROW_ADDR_W-1:0] back_raddr,
  input  logic [TOTAL_W-1:0]    keep_rdata,
  input  logic [TOTAL_W-1:0]    back_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DELAY = 4'b0010,
    S_ROWS  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   slot;
  logic [FILL_W-1:0]   fill;
  logic [SUM_W-1:0]    total;
  logic [VALUE_W-1:0]  sample;
  logic                last;
  logic [CNT_W-1:0]    jcur;
  logic [TOTAL_W-1:0]  best;

  logic                accept;
  logic [SLOT_W-1:0]   prev;
  logic [SLOT_W-1:0]   slot_next;
  logic [FILL_W-1:0]   two_len;
  logic                upd;
  logic                keep_ok;
  logic                back_ok;
  logic [CNT_W-1:0]    rj;
  logic [CNT_W-1:0]    rj_keep;
  logic [CNT_W-1:0]    rj_back;
  logic [CNT_W-1:0]    jw;
  logic [VALUE_W-1:0]  old;
  logic [TOTAL_W-1:0]  keep;
  logic [TOTAL_W-1:0]  back;
  logic [TOTAL_W-1:0]  take;
  logic [TOTAL_W-1:0]  pick;
  logic                out_load;

  assign idle     = (state == S_IDLE);
  assign in_ready = idle & ~cfg_valid;
  assign accept   = in_valid & in_ready;

  assign prev      = (slot == '0) ? SLOT_W'(cfg.window_len - LEN_W'(1)) : slot - SLOT_W'(1);
  assign slot_next = ((LEN_W'(slot) + LEN_W'(1)) == cfg.window_len) ? '0 : slot + SLOT_W'(1);

  assign two_len = FILL_W'(cfg.window_len) << 1;
  assign upd     = (fill >= FILL_W'(cfg.window_len));
  assign keep_ok = (fill > FILL_W'(cfg.window_len));
  assign back_ok = (fill >= two_len);

  assign dly_addr  = slot;
  assign dly_we    = (state == S_DELAY);
  assign dly_wdata = sample;
  assign old       = keep_ok ? dly_rdata : '0;

  assign rj         = (state == S_ROWS) ? jcur - CNT_W'(1) : cfg.window_count;
  assign rj_keep    = rj - CNT_W'(1);
  assign rj_back    = rj - CNT_W'(2);
  assign keep_raddr = {prev, rj_keep[J_W-1:0]};
  assign back_raddr = {slot, rj_back[J_W-1:0]};

  assign keep = keep_ok ? keep_rdata : '0;
  assign back = (back_ok && jcur >= CNT_W'(2)) ? back_rdata : '0;
  assign take = back + TOTAL_W'(total);
  assign pick = (take > keep) ? take : keep;

  assign jw        = jcur - CNT_W'(1);
  assign row_we    = (state == S_ROWS);
  assign row_waddr = {slot, jw[J_W-1:0]};
  assign row_wdata = pick;

  assign out_load = (state == S_DONE) && last && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      fill      <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (clear) begin
            slot  <= '0;
            fill  <= '0;
            total <= '0;
          end else if (accept) begin
            if (fill != FILL_W'(FILL_MAX)) begin
              fill <= fill + FILL_W'(1);
            end
            state <= S_DELAY;
          end
        end
        S_DELAY: begin
          total <= total + SUM_W'(sample) - SUM_W'(old);
          if (upd && cfg.window_count != '0) begin
            state <= S_ROWS;
          end else begin
            state <= S_DONE;
          end
        end
        S_ROWS: begin
          if (jcur == CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!last) begin
            slot  <= slot_next;
            state <= S_IDLE;
          end else if (out_load) begin
            out_valid <= 1'b1;
            slot      <= '0;
            fill      <= '0;
            total     <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= sample_value;
      last   <= last_item;
    end
    if (state == S_DELAY) begin
      jcur <= cfg.window_count;
      best <= '0;
    end else if (state == S_ROWS) begin
      jcur <= jcur - CNT_W'(1);
      if (jcur == cfg.window_count) begin
        best <= pick;
      end
    end
    if (out_load) begin
      best_total <= best;
    end
  end

endmodule

// ===== rtl/k_disjoint_window_max_sum.sv =====
// ----------------------------------------------------------------------------
// k_disjoint_window_max_sum
// Largest total of at most window_count disjoint windows of window_len items.
// ----------------------------------------------------------------------------
// Each input beat is accepted in the idle state, then reads and rewrites its
// delay line entry, then walks the row entries of the current slot (skipped
// when fewer than window_len items have arrived since the last clear or
// window_count is 0), then finishes; no new beat is taken until it is done.
// The row walk handles one entry a cycle through the row memory's write port.
// A beat with last_item set yields one best_total beat and clears the stream;
// it holds in its finishing cycle while an earlier best_total beat waits. A
// write to either register clears the stream too. Neither needs a memory sweep:
// a fill count marks which delay line and row entries hold data of the current
// stream.
module k_disjoint_window_max_sum import kdwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_W-1:0]    sample_value,
  input  logic                  last_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOTAL_W-1:0]    best_total
);

  cfg_t                  cfg;
  logic                  clear;
  logic                  idle;
  logic                  dly_we;
  logic [SLOT_W-1:0]     dly_addr;
  logic [VALUE_W-1:0]    dly_wdata;
  logic [VALUE_W-1:0]    dly_rdata;
  logic                  row_we;
  logic [ROW_ADDR_W-1:0] row_waddr;
  logic [TOTAL_W-1:0]    row_wdata;
  logic [ROW_ADDR_W-1:0] keep_raddr;
  logic [ROW_ADDR_W-1:0] back_raddr;
  logic [TOTAL_W-1:0]    keep_rdata;
  logic [TOTAL_W-1:0]    back_rdata;

  assign cfg_ready = idle;

  kdwm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  kdwm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .clear        (clear),
    .cfg_valid    (cfg_valid),
    .idle         (idle),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .best_total   (best_total),
    .dly_we       (dly_we),
    .dly_addr     (dly_addr),
    .dly_wdata    (dly_wdata),
    .dly_rdata    (dly_rdata),
    .row_we       (row_we),
    .row_waddr    (row_waddr),
    .row_wdata    (row_wdata),
    .keep_raddr   (keep_raddr),
    .back_raddr   (back_raddr),
    .keep_rdata   (keep_rdata),
    .back_rdata   (back_rdata)
  );

  kdwm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_WINDOW),
    .AW    (SLOT_W)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_addr),
    .wdata (dly_wdata),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  kdwm_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (ROW_DEPTH),
    .AW    (ROW_ADDR_W)
  ) u_row_ram_keep (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (keep_raddr),
    .rdata (keep_rdata)
  );

  kdwm_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (ROW_DEPTH),
    .AW    (ROW_ADDR_W)
  ) u_row_ram_back (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

endmodule
